// ----- hw/rtl/lswc_pkg.sv -----
// Shared types, constants and helpers for the line segment window clipper.
// Used by the clipper core, its multiply/divide unit and the port checker.
// Depends on nothing else.
package lswc_pkg;

    // Coordinate width and derived operand widths.
    localparam int COORD_BITS         = 24;
    localparam int OP_BITS            = COORD_BITS + 1;
    localparam int PROD_BITS          = 2 * OP_BITS;
    localparam int MAX_PASSES_DEFAULT = 8;
    localparam int CFG_INDEX_BITS     = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OP_BITS-1:0]    op_t;
    typedef logic        [OP_BITS-1:0]    mag_t;
    typedef logic        [3:0]            outcode_t;

    // Bit positions of the outside flags.
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_BOTTOM = 2;
    localparam int FLAG_TOP    = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEFT   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TOP    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RIGHT  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_BOTTOM = CFG_INDEX_BITS'(3);

    localparam coord_t WINDOW_MIN_RESET = '0;
    localparam coord_t WINDOW_MAX_RESET = COORD_BITS'(32'd8388607);

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_t;

    typedef struct packed {
        coord_t clipped_start_x;
        coord_t clipped_start_y;
        coord_t clipped_end_x;
        coord_t clipped_end_y;
        logic   is_visible;
        logic   pass_limit_hit;
    } clip_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_MOVE,
        ST_WAIT
    } clip_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    // Request to the multiply/divide unit: |num_a * num_b| / |den|.
    typedef struct packed {
        logic start;
        op_t  num_a;
        op_t  num_b;
        op_t  den;
    } md_req_t;

    typedef struct packed {
        logic done;
        mag_t quot;
        logic rem_nz;
    } md_rsp_t;

    function automatic op_t widen(coord_t v);
        return {v[COORD_BITS-1], v};
    endfunction

    function automatic outcode_t outcode(coord_t x, coord_t y, coord_t left, coord_t top,
                                         coord_t right, coord_t bottom);
        outcode_t code;
        code              = '0;
        code[FLAG_LEFT]   = (x < left);
        code[FLAG_RIGHT]  = (x > right);
        code[FLAG_BOTTOM] = (y > bottom);
        code[FLAG_TOP]    = (y < top);
        return code;
    endfunction

endpackage

// ----- hw/rtl/lswc_muldiv.sv -----
// Shared multiply and restoring divide unit of the clipper.
// Forms |a*b| in its MUL state, then divides by |den| one quotient bit per cycle.
// Depends on lswc_pkg.
module lswc_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  lswc_pkg::md_req_t req,
    output lswc_pkg::md_rsp_t rsp
);

    localparam int OPW       = lswc_pkg::OP_BITS;
    localparam int PW        = lswc_pkg::PROD_BITS;
    localparam int CNT_BITS  = $clog2(PW);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(PW - 1);

    lswc_pkg::md_state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    lswc_pkg::mag_t      ua_reg, ua_next, ub_reg, ub_next, ud_reg, ud_next;
    logic [PW-1:0]       pq_reg, pq_next;
    logic [OPW-1:0]      rem_reg, rem_next;

    logic [OPW:0]        rem_shift;
    logic [OPW:0]        rem_sub;
    logic                rem_ge;
    logic [PW-1:0]       product;

    function automatic lswc_pkg::mag_t mag_of(lswc_pkg::op_t v);
        return v[OPW-1] ? lswc_pkg::mag_t'(-v) : lswc_pkg::mag_t'(v);
    endfunction

    assign product   = ua_reg * ub_reg;
    assign rem_shift = {rem_reg, pq_reg[PW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, ud_reg});
    assign rem_sub   = rem_shift - {1'b0, ud_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        ud_next    = ud_reg;
        pq_next    = pq_reg;
        rem_next   = rem_reg;
        case (state_reg)
            lswc_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    ua_next    = mag_of(req.num_a);
                    ub_next    = mag_of(req.num_b);
                    ud_next    = mag_of(req.den);
                    state_next = lswc_pkg::MD_MUL;
                end
            end
            lswc_pkg::MD_MUL:
            begin
                pq_next    = product;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = lswc_pkg::MD_DIV;
            end
            lswc_pkg::MD_DIV:
            begin
                // The product shifts out at the top while quotient bits enter below.
                pq_next  = {pq_reg[PW-2:0], rem_ge};
                rem_next = rem_ge ? rem_sub[OPW-1:0] : rem_shift[OPW-1:0];
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    done_next  = 1'b1;
                    state_next = lswc_pkg::MD_IDLE;
                end
            end
            default:
            begin
                state_next = lswc_pkg::MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lswc_pkg::MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        ud_reg  <= ud_next;
        pq_reg  <= pq_next;
        rem_reg <= rem_next;
    end

    // The quotient never exceeds the magnitude of one operand, so OP_BITS hold it.
    always_comb
    begin
        rsp.done   = done_reg;
        rsp.quot   = pq_reg[OPW-1:0];
        rsp.rem_nz = |rem_reg;
    end

endmodule

// ----- hw/rtl/line_segment_window_clipper_core.sv -----
// Line segment window clipper core; uses lswc_pkg and lswc_muldiv.
// Each pass tests the segment and moves one endpoint; a dividing pass waits on the
// multiply/divide unit, a vertical pass does not; at most MAX_PASSES passes are made.
// Throughput: one segment at a time; the bit-serial divider sets the dividing pass time, and
// the next segment is taken the cycle after the result is loaded into the output register.
// Reset (rst_n, asynchronous, active low) clears control and loads the default window.
module line_segment_window_clipper_core #(
    parameter int MAX_PASSES = lswc_pkg::MAX_PASSES_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  seg_valid,
    output logic                                  seg_stall,
    input  lswc_pkg::seg_t                        seg,
    output logic                                  clip_valid,
    input  logic                                  clip_stall,
    output lswc_pkg::clip_t                       clip,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lswc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  lswc_pkg::coord_t                      cfg_data
);

    localparam int CW        = lswc_pkg::COORD_BITS;
    localparam int OPW       = lswc_pkg::OP_BITS;
    localparam int T_BITS    = CW + 3;
    localparam int PASS_BITS = $clog2(MAX_PASSES + 1);
    localparam logic [PASS_BITS-1:0] PASS_LIMIT = PASS_BITS'(MAX_PASSES);
    localparam logic signed [T_BITS-1:0] T_ONE = T_BITS'(1);

    lswc_pkg::clip_state_t state_reg, state_next;
    logic [PASS_BITS-1:0]  pass_reg, pass_next;
    logic                  clip_valid_reg, clip_valid_next;
    lswc_pkg::clip_t       clip_reg, clip_next;
    lswc_pkg::coord_t      left_reg, left_next, top_reg, top_next;
    lswc_pkg::coord_t      right_reg, right_next, bottom_reg, bottom_next;
    lswc_pkg::coord_t      x1_reg, x1_next, y1_reg, y1_next;
    lswc_pkg::coord_t      x2_reg, x2_next, y2_reg, y2_next;
    lswc_pkg::outcode_t    code_reg, code_next;
    logic                  neg_reg, neg_next;

    lswc_pkg::outcode_t    f1, f2;
    logic                  seg_in, seg_out, at_limit;
    logic                  vertical, use_x, den_zero, neg;
    lswc_pkg::coord_t      edge_val, vert_y, base;
    lswc_pkg::op_t         dx, dy, num_a, num_b, den;
    logic signed [T_BITS-1:0] base_w, quot_w, t_sum, t_fin;
    lswc_pkg::md_req_t     md_req;
    lswc_pkg::md_rsp_t     md_rsp;

    lswc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign cfg_ready  = 1'b1;
    assign seg_stall  = (state_reg != lswc_pkg::ST_IDLE);
    assign clip_valid = clip_valid_reg;
    assign clip       = clip_reg;

    // Pass test on the current endpoints.
    assign f1       = lswc_pkg::outcode(x1_reg, y1_reg, left_reg, top_reg, right_reg, bottom_reg);
    assign f2       = lswc_pkg::outcode(x2_reg, y2_reg, left_reg, top_reg, right_reg, bottom_reg);
    assign seg_in   = (f1 == '0) && (f2 == '0);
    assign seg_out  = |(f1 & f2);
    assign at_limit = (pass_reg >= PASS_LIMIT);

    // Move setup, from the first endpoint's flags held in code_reg.
    assign vertical = (x1_reg == x2_reg);
    assign use_x    = code_reg[lswc_pkg::FLAG_LEFT] | code_reg[lswc_pkg::FLAG_RIGHT];
    assign dx       = lswc_pkg::widen(x2_reg) - lswc_pkg::widen(x1_reg);
    assign dy       = lswc_pkg::widen(y2_reg) - lswc_pkg::widen(y1_reg);

    always_comb
    begin
        if (code_reg[lswc_pkg::FLAG_LEFT])
        begin
            edge_val = left_reg;
        end
        else if (code_reg[lswc_pkg::FLAG_RIGHT])
        begin
            edge_val = right_reg;
        end
        else if (code_reg[lswc_pkg::FLAG_BOTTOM])
        begin
            edge_val = bottom_reg;
        end
        else
        begin
            edge_val = top_reg;
        end
    end

    // A vertical segment only snaps its y, and only for a top or bottom flag.
    always_comb
    begin
        if (code_reg[lswc_pkg::FLAG_TOP])
        begin
            vert_y = top_reg;
        end
        else if (code_reg[lswc_pkg::FLAG_BOTTOM])
        begin
            vert_y = bottom_reg;
        end
        else
        begin
            vert_y = y1_reg;
        end
    end

    assign base     = use_x ? y1_reg : x1_reg;
    assign num_a    = lswc_pkg::widen(edge_val) - lswc_pkg::widen(use_x ? x1_reg : y1_reg);
    assign num_b    = use_x ? dy : dx;
    assign den      = use_x ? dx : dy;
    assign den_zero = (den == '0);
    assign neg      = num_a[OPW-1] ^ num_b[OPW-1] ^ den[OPW-1];

    // Signed result with truncation toward zero of the whole rational value.
    assign base_w = {{3{base[CW-1]}}, base};
    assign quot_w = {2'b00, md_rsp.quot};
    assign t_sum  = neg_reg ? (base_w - quot_w) : (base_w + quot_w);

    always_comb
    begin
        t_fin = t_sum;
        if (md_rsp.rem_nz)
        begin
            if ((t_sum > 0) && neg_reg)
            begin
                t_fin = t_sum - T_ONE;
            end
            else if ((t_sum < 0) && !neg_reg)
            begin
                t_fin = t_sum + T_ONE;
            end
        end
    end

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lswc_pkg::REG_WINDOW_LEFT:   left_next   = cfg_data;
                lswc_pkg::REG_WINDOW_TOP:    top_next    = cfg_data;
                lswc_pkg::REG_WINDOW_RIGHT:  right_next  = cfg_data;
                lswc_pkg::REG_WINDOW_BOTTOM: bottom_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        clip_valid_next = clip_valid_reg;
        clip_next       = clip_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        x2_next         = x2_reg;
        y2_next         = y2_reg;
        code_next       = code_reg;
        neg_next        = neg_reg;
        md_req.start    = 1'b0;
        md_req.num_a    = num_a;
        md_req.num_b    = num_b;
        md_req.den      = den;

        if (clip_valid_reg && !clip_stall)
        begin
            clip_valid_next = 1'b0;
        end

        case (state_reg)
            lswc_pkg::ST_IDLE:
            begin
                if (seg_valid)
                begin
                    x1_next    = seg.start_x;
                    y1_next    = seg.start_y;
                    x2_next    = seg.end_x;
                    y2_next    = seg.end_y;
                    pass_next  = '0;
                    state_next = lswc_pkg::ST_TEST;
                end
            end
            lswc_pkg::ST_TEST:
            begin
                if (seg_in || seg_out || at_limit)
                begin
                    // The result waits here until the output register is free.
                    if (!clip_valid_reg || !clip_stall)
                    begin
                        clip_next.clipped_start_x = x1_reg;
                        clip_next.clipped_start_y = y1_reg;
                        clip_next.clipped_end_x   = x2_reg;
                        clip_next.clipped_end_y   = y2_reg;
                        clip_next.is_visible      = seg_in || !seg_out;
                        clip_next.pass_limit_hit  = !seg_in && !seg_out;
                        clip_valid_next           = 1'b1;
                        state_next                = lswc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // The endpoint to move always comes first.
                    if (f1 == '0)
                    begin
                        x1_next   = x2_reg;
                        y1_next   = y2_reg;
                        x2_next   = x1_reg;
                        y2_next   = y1_reg;
                        code_next = f2;
                    end
                    else
                    begin
                        code_next = f1;
                    end
                    state_next = lswc_pkg::ST_MOVE;
                end
            end
            lswc_pkg::ST_MOVE:
            begin
                if (vertical)
                begin
                    y1_next    = vert_y;
                    pass_next  = pass_reg + PASS_BITS'(1);
                    state_next = lswc_pkg::ST_TEST;
                end
                else if (den_zero)
                begin
                    if (use_x)
                    begin
                        x1_next = edge_val;
                    end
                    else
                    begin
                        y1_next = edge_val;
                    end
                    pass_next  = pass_reg + PASS_BITS'(1);
                    state_next = lswc_pkg::ST_TEST;
                end
                else
                begin
                    md_req.start = 1'b1;
                    neg_next     = neg;
                    state_next   = lswc_pkg::ST_WAIT;
                end
            end
            lswc_pkg::ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    if (use_x)
                    begin
                        x1_next = edge_val;
                        y1_next = t_fin[CW-1:0];
                    end
                    else
                    begin
                        x1_next = t_fin[CW-1:0];
                        y1_next = edge_val;
                    end
                    pass_next  = pass_reg + PASS_BITS'(1);
                    state_next = lswc_pkg::ST_TEST;
                end
            end
            default:
            begin
                state_next = lswc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lswc_pkg::ST_IDLE;
            pass_reg       <= '0;
            clip_valid_reg <= 1'b0;
            left_reg       <= lswc_pkg::WINDOW_MIN_RESET;
            top_reg        <= lswc_pkg::WINDOW_MIN_RESET;
            right_reg      <= lswc_pkg::WINDOW_MAX_RESET;
            bottom_reg     <= lswc_pkg::WINDOW_MAX_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            clip_valid_reg <= clip_valid_next;
            left_reg       <= left_next;
            top_reg        <= top_next;
            right_reg      <= right_next;
            bottom_reg     <= bottom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clip_reg <= clip_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        code_reg <= code_next;
        neg_reg  <= neg_next;
    end

endmodule

// ----- hw/rtl/lswc_checker.sv -----
// Port-level checker for the clipper core, attached by the bind below.
// Depends on lswc_pkg and line_segment_window_clipper_core.
module lswc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            seg_valid,
    input logic            seg_stall,
    input logic            clip_valid,
    input logic            clip_stall,
    input lswc_pkg::clip_t clip
);

    // A stalled result stays offered.
    a_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && clip_stall |=> clip_valid)
        else $error("clip request dropped while stalled");

    // A stalled result keeps its payload.
    a_clip_stable: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && clip_stall |=> $stable(clip))
        else $error("clip payload changed while stalled");

    // Running out of passes always reports the segment as visible.
    a_limit_visible: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && clip.pass_limit_hit |-> clip.is_visible)
        else $error("pass limit reported on an invisible segment");

    // The core works on one segment at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_stall |=> seg_stall)
        else $error("second segment accepted while clipping");

endmodule

bind line_segment_window_clipper_core lswc_checker u_lswc_checker (.*);
